/* src/htfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_pkg
// shared types and constants of the greeting-then-frame deframer
// ----------------------------------------------------------------------------
package htfd_pkg;

   typedef enum logic [1:0] {
      SEC_GREETING = 2'd0,
      SEC_HEADER   = 2'd1,
      SEC_PAYLOAD  = 2'd2
   } section_type;

   typedef enum logic [1:0] {
      FLT_NONE    = 2'd0,
      FLT_HEADER  = 2'd1,
      FLT_LENGTH  = 2'd2,
      FLT_DROPPED = 2'd3
   } fault_type;

   // frame header layout
   localparam logic [31:0] FRAME_MAGIC     = 32'h4253_5552;
   localparam logic [7:0]  FRAME_VERSION   = 8'd1;
   localparam int          VERSION_AT      = 4;
   localparam int          SIZE_FIELD_AT   = 6;
   localparam int          LENGTH_FIELD_AT = 12;

   // one result transfer
   typedef struct packed {
      logic [7:0]  byte_out;
      section_type section;
      logic        greeting_end;
      logic        frame_end;
      fault_type   fault;
   } result_type;

endpackage

/* src/htfd_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_step
// per-byte parse logic: next state and result for one received byte
// ----------------------------------------------------------------------------
module htfd_step #(
   parameter int GREETING_BYTES = 64,
   parameter int HEADER_BYTES   = 16,
   parameter int MAX_PAYLOAD    = 65536,
   parameter int OFF_W          = 6
) (
   input  logic [7:0]           byte_in,
   input  htfd_pkg::section_type section_cur,
   input  logic [OFF_W-1:0]     offset_cur,
   input  logic [31:0]          length_cur,
   input  logic                 header_bad_cur,
   input  logic                 failed_cur,
   output htfd_pkg::section_type section_nxt,
   output logic [OFF_W-1:0]     offset_nxt,
   output logic [31:0]          length_nxt,
   output logic                 header_bad_nxt,
   output logic                 failed_nxt,
   output htfd_pkg::result_type result
);
   import htfd_pkg::*;

   localparam logic [OFF_W-1:0] GREET_LAST = OFF_W'(GREETING_BYTES - 1);
   localparam logic [OFF_W-1:0] HDR_LAST   = OFF_W'(HEADER_BYTES - 1);
   localparam logic [15:0]      HDR_SIZE   = 16'(HEADER_BYTES);
   localparam logic [31:0]      MAX_LEN    = 32'(MAX_PAYLOAD);
   localparam logic [OFF_W-1:0] OFF_VER    = OFF_W'(VERSION_AT);
   localparam logic [OFF_W-1:0] OFF_SIZE   = OFF_W'(SIZE_FIELD_AT);
   localparam logic [OFF_W-1:0] OFF_LEN    = OFF_W'(LENGTH_FIELD_AT);
   localparam logic [OFF_W-1:0] OFF_LEN_END = OFF_W'(LENGTH_FIELD_AT + 4);

   logic        bad_now;
   logic [31:0] len_cap;
   logic [31:0] len_dec;

   always_comb begin
      bad_now = header_bad_cur;
      len_cap = length_cur;
      len_dec = (length_cur != 32'd0) ? length_cur - 32'd1 : length_cur;

      // header field checks and length capture
      if (offset_cur < OFF_W'(4)) begin
         if (byte_in != FRAME_MAGIC[{offset_cur[1:0], 3'b000} +: 8]) begin
            bad_now = 1'b1;
         end
      end else if (offset_cur == OFF_VER) begin
         if (byte_in != FRAME_VERSION) begin
            bad_now = 1'b1;
         end
      end else if (offset_cur == OFF_SIZE) begin
         if (byte_in != HDR_SIZE[7:0]) begin
            bad_now = 1'b1;
         end
      end else if (offset_cur == OFF_SIZE + OFF_W'(1)) begin
         if (byte_in != HDR_SIZE[15:8]) begin
            bad_now = 1'b1;
         end
      end else if (offset_cur >= OFF_LEN && offset_cur < OFF_LEN_END) begin
         len_cap[{offset_cur[1:0], 3'b000} +: 8] = byte_in;
      end

      section_nxt    = section_cur;
      offset_nxt     = offset_cur;
      length_nxt     = length_cur;
      header_bad_nxt = header_bad_cur;
      failed_nxt     = failed_cur;

      result.byte_out     = byte_in;
      result.section      = section_cur;
      result.greeting_end = 1'b0;
      result.frame_end    = 1'b0;
      result.fault        = FLT_NONE;

      if (failed_cur) begin
         result.fault = FLT_DROPPED;
      end else begin
         unique case (section_cur)
            SEC_GREETING: begin
               if (offset_cur >= GREET_LAST) begin
                  result.greeting_end = 1'b1;
                  section_nxt    = SEC_HEADER;
                  offset_nxt     = '0;
                  length_nxt     = '0;
                  header_bad_nxt = 1'b0;
               end else begin
                  offset_nxt = offset_cur + OFF_W'(1);
               end
            end
            SEC_PAYLOAD: begin
               length_nxt = len_dec;
               if (len_dec == 32'd0) begin
                  result.frame_end = 1'b1;
                  section_nxt    = SEC_HEADER;
                  offset_nxt     = '0;
                  header_bad_nxt = 1'b0;
               end
            end
            default: begin
               // frame header, also the unused section code
               result.section = SEC_HEADER;
               length_nxt     = len_cap;
               header_bad_nxt = bad_now;
               if (offset_cur >= HDR_LAST) begin
                  if (bad_now) begin
                     result.fault = FLT_HEADER;
                     failed_nxt   = 1'b1;
                  end else if (len_cap > MAX_LEN) begin
                     result.fault = FLT_LENGTH;
                     failed_nxt   = 1'b1;
                  end else if (len_cap == 32'd0) begin
                     result.frame_end = 1'b1;
                     section_nxt    = SEC_HEADER;
                     offset_nxt     = '0;
                     length_nxt     = '0;
                     header_bad_nxt = 1'b0;
                  end else begin
                     section_nxt = SEC_PAYLOAD;
                     offset_nxt  = '0;
                  end
               end else begin
                  section_nxt = SEC_HEADER;
                  offset_nxt  = offset_cur + OFF_W'(1);
               end
            end
         endcase
      end
   end

endmodule

/* src/hello_then_frame_deframer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hello_then_frame_deframer_core
// byte-serial deframer: fixed greeting block, then length-prefixed frames
// ----------------------------------------------------------------------------
//  channel | dir | ports                                         | meaning
//  req     | in  | req_valid req_ready req_byte_in               | one stream byte
//  rsp     | out | rsp_valid rsp_ready rsp_byte_out rsp_section  | byte with marks
//          |     | rsp_greeting_end rsp_frame_end rsp_fault      |
//
//  one byte per cycle unless rsp stalls; a result shows in the cycle after its byte is taken
//  the parse state and the result register both advance on a req transfer
//  req_ready is high while the result register is empty or being drained
//  reset (synchronous) returns the parser to the start of the greeting
//  a fault sticks until reset; later bytes come back marked as dropped
// ----------------------------------------------------------------------------
module hello_then_frame_deframer_core #(
   parameter int GREETING_BYTES = 64,
   parameter int HEADER_BYTES   = 16,
   parameter int MAX_PAYLOAD    = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_byte_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_byte_out,
   output logic [1:0]            rsp_section,
   output logic                  rsp_greeting_end,
   output logic                  rsp_frame_end,
   output logic [1:0]            rsp_fault
);
   import htfd_pkg::*;

   // offset counter spans the longer of greeting and header, with one spare
   // bit so the end of the length field is always representable
   localparam int OFF_W = $clog2((GREETING_BYTES > HEADER_BYTES) ?
                                 GREETING_BYTES : HEADER_BYTES) + 1;

   // parse state
   section_type       section_ff, section_in;
   logic [OFF_W-1:0]  offset_ff, offset_in;
   logic [31:0]       length_ff, length_in;
   logic              header_bad_ff, header_bad_in;
   logic              failed_ff, failed_in;

   // result register
   logic              rsp_valid_ff;
   result_type        result_ff, result_in;

   logic              req_xfer;

   // take a byte whenever the result slot is free or empties this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   htfd_step #(
      .GREETING_BYTES (GREETING_BYTES),
      .HEADER_BYTES   (HEADER_BYTES),
      .MAX_PAYLOAD    (MAX_PAYLOAD),
      .OFF_W          (OFF_W)
   ) u_step (
      .byte_in        (req_byte_in),
      .section_cur    (section_ff),
      .offset_cur     (offset_ff),
      .length_cur     (length_ff),
      .header_bad_cur (header_bad_ff),
      .failed_cur     (failed_ff),
      .section_nxt    (section_in),
      .offset_nxt     (offset_in),
      .length_nxt     (length_in),
      .header_bad_nxt (header_bad_in),
      .failed_nxt     (failed_in),
      .result         (result_in)
   );

   // parse state advances only on a req transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff    <= SEC_GREETING;
         offset_ff     <= '0;
         length_ff     <= '0;
         header_bad_ff <= 1'b0;
         failed_ff     <= 1'b0;
      end else if (req_xfer) begin
         section_ff    <= section_in;
         offset_ff     <= offset_in;
         length_ff     <= length_in;
         header_bad_ff <= header_bad_in;
         failed_ff     <= failed_in;
      end
   end

   // result valid: set by a req transfer, cleared when rsp is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_byte_out     = result_ff.byte_out;
   assign rsp_section      = result_ff.section;
   assign rsp_greeting_end = result_ff.greeting_end;
   assign rsp_frame_end    = result_ff.frame_end;
   assign rsp_fault        = result_ff.fault;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the greeting-then-frame deframer byte by byte: a greeting block,
// directed and random length-prefixed frames with and without random stalls on
// both channels, then a single sticky fault and the dropped bytes after it;
// every result transfer is compared field by field with a local prediction
// of the parser
// ----------------------------------------------------------------------------
module testbench;
   import htfd_pkg::*;

   localparam int GREETING_BYTES = 64;
   localparam int HEADER_BYTES   = 16;
   localparam int MAX_PAYLOAD    = 65536;

   // a header that is sent as built, with no corrupted byte
   localparam int NO_CORRUPTION = -1;
   // header positions whose content is checked by the block
   localparam int CHECKED_AT [7] = '{0, 1, 2, 3, VERSION_AT, SIZE_FIELD_AT,
                                     SIZE_FIELD_AT + 1};

   localparam int TIME_LIMIT_NS = 2_000_000;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_byte_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_byte_out;
   logic [1:0] rsp_section;
   logic       rsp_greeting_end;
   logic       rsp_frame_end;
   logic [1:0] rsp_fault;

   // idle odds in percent for each side of the block
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   int unsigned bytes_sent     = 0;
   int unsigned mismatch_count = 0;

   // predicted parser state
   section_type parse_section = SEC_GREETING;
   logic [16:0] parse_offset  = '0;
   logic [31:0] length_left   = '0;
   logic        header_failed = 1'b0;
   logic        stream_failed = 1'b0;

   // predicted results, oldest first
   result_type expected_results [$];

   hello_then_frame_deframer_core #(
      .GREETING_BYTES (GREETING_BYTES),
      .HEADER_BYTES   (HEADER_BYTES),
      .MAX_PAYLOAD    (MAX_PAYLOAD)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_byte_in      (req_byte_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_section      (rsp_section),
      .rsp_greeting_end (rsp_greeting_end),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_fault        (rsp_fault)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(TIME_LIMIT_NS);
      $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // parser prediction
   // ------------------------------------------------------------------------

   task automatic open_header();
      parse_section = SEC_HEADER;
      parse_offset  = '0;
      length_left   = '0;
      header_failed = 1'b0;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      result_type  r;
      logic [16:0] off;
      r.byte_out     = b;
      r.section      = parse_section;
      r.greeting_end = 1'b0;
      r.frame_end    = 1'b0;
      r.fault        = FLT_NONE;
      if (stream_failed) begin
         // sticky fault: byte dropped, state frozen
         r.fault = FLT_DROPPED;
      end else if (parse_section == SEC_GREETING) begin
         if (parse_offset >= 17'(GREETING_BYTES - 1)) begin
            r.greeting_end = 1'b1;
            open_header();
         end else begin
            parse_offset = parse_offset + 1'b1;
         end
      end else if (parse_section == SEC_PAYLOAD) begin
         if (length_left != 0) length_left = length_left - 1'b1;
         if (length_left == 0) begin
            r.frame_end = 1'b1;
            open_header();
         end
      end else begin
         off       = parse_offset;
         r.section = SEC_HEADER;
         if (off < 4) begin
            if (b != 8'(FRAME_MAGIC >> (8 * off))) header_failed = 1'b1;
         end else if (off == VERSION_AT) begin
            if (b != FRAME_VERSION) header_failed = 1'b1;
         end else if (off == SIZE_FIELD_AT) begin
            if (b != 8'(HEADER_BYTES)) header_failed = 1'b1;
         end else if (off == SIZE_FIELD_AT + 1) begin
            if (b != 8'(HEADER_BYTES >> 8)) header_failed = 1'b1;
         end else if (off >= LENGTH_FIELD_AT && off < LENGTH_FIELD_AT + 4) begin
            length_left = length_left | (32'(b) << (8 * (off - LENGTH_FIELD_AT)));
         end

         if (off >= 17'(HEADER_BYTES - 1)) begin
            if (header_failed) begin
               r.fault       = FLT_HEADER;
               stream_failed = 1'b1;
            end else if (length_left > 32'(MAX_PAYLOAD)) begin
               r.fault       = FLT_LENGTH;
               stream_failed = 1'b1;
            end else if (length_left == 0) begin
               // empty payload ends the frame on the last header byte
               r.frame_end = 1'b1;
               open_header();
            end else begin
               parse_section = SEC_PAYLOAD;
               parse_offset  = '0;
            end
         end else begin
            parse_offset = off + 1'b1;
         end
      end
      expected_results.push_back(r);
   endtask

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------

   task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // one req transfer; valid is lowered only when a gap is taken, so a
   // back-to-back byte keeps it high without a glitch
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(b);
      bytes_sent++;
   endtask

   // header with magic, version, size and length in place; the other bytes
   // are random; one byte may be corrupted by a nonzero xor
   task automatic send_header(input logic [31:0] len, input int bad_at,
                              input logic [7:0] bad_xor);
      logic [7:0] hdr [HEADER_BYTES];
      for (int i = 0; i < HEADER_BYTES; i++) hdr[i] = 8'($urandom_range(255));
      for (int i = 0; i < 4; i++) begin
         hdr[i]                   = 8'(FRAME_MAGIC >> (8 * i));
         hdr[LENGTH_FIELD_AT + i] = 8'(len >> (8 * i));
      end
      hdr[VERSION_AT]        = FRAME_VERSION;
      hdr[SIZE_FIELD_AT]     = 8'(HEADER_BYTES);
      hdr[SIZE_FIELD_AT + 1] = 8'(HEADER_BYTES >> 8);
      if (bad_at != NO_CORRUPTION) hdr[bad_at] = hdr[bad_at] ^ bad_xor;
      for (int i = 0; i < HEADER_BYTES; i++) send_byte(hdr[i]);
   endtask

   task automatic send_frame(input logic [31:0] len);
      send_header(len, NO_CORRUPTION, 8'h00);
      for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(255)));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // greeting block with both extreme byte values inside it
   task automatic test_greeting();
      send_byte(8'h00);
      send_byte(8'hFF);
      for (int i = 2; i < GREETING_BYTES - 1; i++) send_byte(8'($urandom_range(255)));
      send_byte(8'hFF);
   endtask

   // empty frame, then single-byte payloads at both extremes
   task automatic test_short_frames();
      send_frame(32'd0);
      send_header(32'd1, NO_CORRUPTION, 8'h00);
      send_byte(8'h00);
      send_header(32'd1, NO_CORRUPTION, 8'h00);
      send_byte(8'hFF);
   endtask

   // well-formed frames of mostly short random length until the byte count
   // reaches the given mark
   task automatic test_random_frames(input int unsigned until_bytes);
      int unsigned pick;
      logic [31:0] len;
      while (bytes_sent < until_bytes) begin
         pick = $urandom_range(99);
         if (pick < 10)      len = 32'd0;
         else if (pick < 90) len = 32'($urandom_range(24, 1));
         else                len = 32'($urandom_range(300, 25));
         send_frame(len);
      end
   endtask

   // one fault per run since reset is not repeated: either a corrupted
   // checked header byte or an oversized length, then dropped bytes
   task automatic test_fault_and_drop();
      logic [31:0] len;
      if ($urandom_range(1) == 0) begin
         send_header(32'($urandom_range(40)), CHECKED_AT[$urandom_range(6)],
                     8'($urandom_range(255, 1)));
      end else begin
         case ($urandom_range(2))
            0: len = 32'(MAX_PAYLOAD + 1);
            1: len = 32'hFFFF_FFFF;
            default: begin
               len = $urandom;
               if (len <= 32'(MAX_PAYLOAD)) len[31] = 1'b1;
            end
         endcase
         send_header(len, NO_CORRUPTION, 8'h00);
      end
      // noise and a well-formed frame, all of it dropped
      repeat (30) send_byte(8'($urandom_range(255)));
      send_frame(32'd4);
   endtask

   // ------------------------------------------------------------------------
   // result checking and receiver stalls
   // ------------------------------------------------------------------------

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result transfer, expected none, actual %0h",
                        $time, rsp_byte_out);
            end else begin
               want = expected_results.pop_front();
               check_field("byte_out", want.byte_out, rsp_byte_out);
               check_field("section", 8'(want.section), 8'(rsp_section));
               check_field("greeting_end", 8'(want.greeting_end), 8'(rsp_greeting_end));
               check_field("frame_end", 8'(want.frame_end), 8'(rsp_frame_end));
               check_field("fault", 8'(want.fault), 8'(rsp_fault));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // sequence of tests
   // ------------------------------------------------------------------------

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sender idles less than the receiver
      set_idling(37, 58);
      test_greeting();
      test_short_frames();
      test_random_frames(300);

      // the other way round
      set_idling(58, 37);
      test_random_frames(550);

      // no idling
      set_idling(0, 0);
      test_random_frames(820);
      test_fault_and_drop();

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // the wait below catches stray results after the queue empties
      repeat (4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
